>>> hdl/sefo_pkg.sv
// Package: shared types and constants for the sensor event float offset block.
package sefo_pkg;

   localparam logic [31:0] TypeGyro      = 32'd4;
   localparam logic [31:0] TypeGyroUncal = 32'd16;

   typedef enum logic [1:0] {
      CSR_ENABLE    = 2'd0,
      CSR_TYPE_MASK = 2'd1,
      CSR_X_OFFSET  = 2'd2,
      CSR_Y_OFFSET  = 2'd3
   } csr_index_type;

   // Stage 1 -> stage 2: aligned operands
   typedef struct packed {
      logic        bypass;      // result already known
      logic [31:0] bypass_val;
      logic        sign_l;      // sign of larger operand
      logic        sign_s;      // sign of smaller operand
      logic [8:0]  exp;
      logic [23:0] man_l;
      logic [23:0] man_s;       // already shifted
   } align_type;

   // Stage 2 -> stage 3: raw sum/difference
   typedef struct packed {
      logic        bypass;
      logic [31:0] bypass_val;
      logic        sign;
      logic        sub;
      logic [8:0]  exp;
      logic [24:0] man;
   } sum_type;

   // Stage 3 -> stage 4: normalized and packed
   typedef struct packed {
      logic        sign;
      logic [9:0]  exp;         // signed, may go below zero
      logic [22:0] frac;
      logic        bypass;
      logic [31:0] bypass_val;
      logic        zero;
   } norm_type;

   // Count leading zeros of a 24-bit mantissa (0..24)
   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      logic       found;
      n = 5'd24;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 5'(23 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

>>> hdl/sefo_fadd.sv
// Truncating single-precision adder, four register stages with stall.
module sefo_fadd (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,        // pipeline advances this cycle
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic        use_add,    // 0: pass a through
   output logic [31:0] result
);
   import sefo_pkg::*;

   // stage 1: compare and align
   align_type st1_in, st1_ff;
   logic [7:0] ea, eb, gap;
   logic       a_big;
   logic [23:0] ma, mb;

   always_comb begin
      ea = a[30:23];
      eb = b[30:23];
      ma = {1'b1, a[22:0]};
      mb = {1'b1, b[22:0]};
      a_big = (ea >= eb);
      gap = a_big ? (ea - eb) : (eb - ea);
      st1_in = '0;
      st1_in.bypass_val = a;
      if (!use_add) begin
         st1_in.bypass = 1'b1;
      end else if (a[30:0] == 31'd0) begin
         st1_in.bypass = 1'b1;
         st1_in.bypass_val = b;
      end else if (b[30:0] == 31'd0) begin
         st1_in.bypass = 1'b1;
      end else if (gap > 8'd24) begin
         st1_in.bypass = 1'b1;
         st1_in.bypass_val = a_big ? a : b;
      end
      st1_in.exp = {1'b0, a_big ? ea : eb};
      // on equal exponents keep a as "larger"; mantissa compare later
      st1_in.sign_l = a_big ? a[31] : b[31];
      st1_in.sign_s = a_big ? b[31] : a[31];
      st1_in.man_l = a_big ? ma : mb;
      st1_in.man_s = (a_big ? mb : ma) >> gap[4:0];
   end

   // stage 2: add or subtract
   sum_type st2_in, st2_ff;
   always_comb begin
      st2_in.bypass = st1_ff.bypass;
      st2_in.bypass_val = st1_ff.bypass_val;
      st2_in.exp = st1_ff.exp;
      st2_in.sub = (st1_ff.sign_l != st1_ff.sign_s);
      st2_in.sign = st1_ff.sign_l;
      if (!st2_in.sub) begin
         st2_in.man = {1'b0, st1_ff.man_l} + {1'b0, st1_ff.man_s};
      end else if (st1_ff.man_l >= st1_ff.man_s) begin
         st2_in.man = {1'b0, st1_ff.man_l - st1_ff.man_s};
      end else begin
         st2_in.man = {1'b0, st1_ff.man_s - st1_ff.man_l};
         st2_in.sign = st1_ff.sign_s;
      end
   end

   // stage 3: normalize
   norm_type st3_in, st3_ff;
   logic [4:0] lz;
   always_comb begin
      lz = lzc24(st2_ff.man[23:0]);
      st3_in.bypass = st2_ff.bypass;
      st3_in.bypass_val = st2_ff.bypass_val;
      st3_in.sign = st2_ff.sign;
      st3_in.zero = 1'b0;
      if (!st2_ff.sub) begin
         if (st2_ff.man[24]) begin
            st3_in.exp = {1'b0, st2_ff.exp} + 10'd1;
            st3_in.frac = st2_ff.man[23:1];
         end else begin
            st3_in.exp = {1'b0, st2_ff.exp};
            st3_in.frac = st2_ff.man[22:0];
         end
      end else begin
         st3_in.zero = (st2_ff.man[23:0] == 24'd0);
         st3_in.exp = {1'b0, st2_ff.exp} - {5'd0, lz};
         st3_in.frac = 23'(st2_ff.man[23:0] << lz);
      end
   end

   // stage 4: range check and pack
   logic [31:0] res_in, res_ff;
   always_comb begin
      if (st3_ff.bypass) begin
         res_in = st3_ff.bypass_val;
      end else if (st3_ff.zero) begin
         res_in = 32'd0;
      end else if (!st3_ff.exp[9] && st3_ff.exp >= 10'd255) begin
         res_in = {st3_ff.sign, 8'hFF, 23'd0};
      end else if (st3_ff.exp[9] || st3_ff.exp == 10'd0) begin
         res_in = {st3_ff.sign, 31'd0};
      end else begin
         res_in = {st3_ff.sign, st3_ff.exp[7:0], st3_ff.frac};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

   // stage 2 result fits 24 bits after subtraction
   assert property (@(posedge clock) disable iff (reset) st2_ff.sub |-> !st2_ff.man[24])
      else $error("difference overflowed mantissa");

endmodule

>>> hdl/sensor_event_float_offset.sv
// Top level: event matcher, two pipelined float adders and handshake control.
// Every accepted transfer comes out exactly once, in order, and one event can be accepted every
// cycle while the result side does not stall. The adder pipeline has four register stages (align,
// add, normalize, pack); a valid bit travels with each stage and the whole pipeline holds while
// the oldest result waits to be taken, empty stages included, so a bubble is not squeezed out
// during a stall (ready is high when stage 4 is empty or being taken). Matching is done on entry,
// so configuration is sampled as the event enters.
// Offsets are added by a truncating adder: zero operands and exponent gaps over 24 pass an
// operand unchanged, overflow gives signed infinity and underflow or cancellation gives zero.
module sensor_event_float_offset (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_event_type,
   input  logic [31:0]        req_data_x_in,
   input  logic [31:0]        req_data_y_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_data_x_out,
   output logic [31:0]        rsp_data_y_out,
   output logic               rsp_changed,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import sefo_pkg::*;

   localparam int Depth = 4;

   // configuration registers
   logic        enable_ff;
   logic [1:0]  type_mask_ff;
   logic [31:0] x_offset_ff, y_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         type_mask_ff <= 2'b11;
         x_offset_ff  <= 32'd0;
         y_offset_ff  <= 32'd0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            CSR_TYPE_MASK: type_mask_ff <= csr_wdata[1:0];
            CSR_X_OFFSET:  x_offset_ff  <= csr_wdata;
            CSR_Y_OFFSET:  y_offset_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // event match
   logic hit;
   always_comb begin
      hit = 1'b0;
      if (enable_ff) begin
         if (req_event_type == TypeGyro && type_mask_ff[0]) hit = 1'b1;
         if (req_event_type == TypeGyroUncal && type_mask_ff[1]) hit = 1'b1;
      end
   end

   // valid and flag shift line; whole line advances together
   logic [Depth-1:0] vld_ff, vld_in;
   logic [Depth-1:0] hit_ff, hit_in;
   logic             adv;

   // advance when the output slot is free or being drained
   assign adv = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      vld_in = {vld_ff[Depth-2:0], req_valid};
      hit_in = {hit_ff[Depth-2:0], hit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_in;
      end
   end

   sefo_fadd u_add_x (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .a       (req_data_x_in),
      .b       (x_offset_ff),
      .use_add (hit),
      .result  (rsp_data_x_out)
   );

   sefo_fadd u_add_y (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .a       (req_data_y_in),
      .b       (y_offset_ff),
      .use_add (hit),
      .result  (rsp_data_y_out)
   );

   assign rsp_valid   = vld_ff[Depth-1];
   assign rsp_changed = hit_ff[Depth-1];

   // a stalled result holds the line still
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_x_out) && $stable(rsp_changed))
      else $error("stalled result moved");
   // no acceptance while stalled with a full output
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken during stall");
   // an accepted transfer enters stage 1
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted transfer lost");
   // a pass-through result equals its input unchanged when the line did not stall while it passed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_changed && $past(adv) && $past(adv, 2) && $past(adv, 3)
      && $past(adv, 4) |-> rsp_data_x_out == $past(req_data_x_in, 4))
      else $error("pass-through altered");

endmodule
